FILE: design/vdst_pkg.sv
// ----------------------------------------------------------------------------
// vdst_pkg
// shared types and helpers for the vertex dedup table
// ----------------------------------------------------------------------------
package vdst_pkg;

	localparam int unsigned CoordW = 32;
	localparam int unsigned KeyW   = 3 * CoordW;
	localparam int unsigned IdxOutW = 10;

	typedef logic [CoordW-1:0] coord_t;
	typedef logic [KeyW-1:0]   vkey_t;

	// float bits to an unsigned key with the same order, -0 folded onto +0
	function automatic coord_t order_key(input coord_t raw);
		coord_t b;
		b = raw;
		if (b[CoordW-2:0] == '0) begin
			b = '0;
		end
		if (b[CoordW-1]) begin
			return ~b;
		end
		return {1'b1, b[CoordW-2:0]};
	endfunction

endpackage

FILE: design/vdst_ram.sv
// ----------------------------------------------------------------------------
// vdst_ram
// single port write, single port read ram with registered read data
// ----------------------------------------------------------------------------
module vdst_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/vertex_dedup_sorted_table_top.sv
// ----------------------------------------------------------------------------
// vertex_dedup_sorted_table_top
// vertex welding table: binary search over a sorted index list, then append
// ----------------------------------------------------------------------------
// search: each probe steps through S_PROBE, S_RDORD, S_RDKEY and S_CMP; on insertion
//   each sorted-list entry from position up to count moves via S_SHRD and S_SHWR, then S_DONE places the new one
// throughput: one beat at a time; one key compare unit and one read port
//   per ram set the pace
// reset clears the count and control; the rams hold no reset value
module vertex_dedup_sorted_table_top #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  vdst_pkg::coord_t          coord_x,
	input  vdst_pkg::coord_t          coord_y,
	input  vdst_pkg::coord_t          coord_z,
	input  logic                      restart,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [9:0]                vertex_index,
	output logic                      is_new,
	output logic                      table_full
);
	import vdst_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = AW + 1;
	localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_PROBE, S_RDORD, S_RDKEY, S_CMP,
		S_SHRD, S_SHWR, S_DONE, S_OUT
	} state_t;

	state_t        state_q;
	logic [CW-1:0] count_q, lo_q, hi_q, pos_q;
	logic [AW-1:0] mid_q;
	vkey_t         key_q;

	logic          ord_we, key_we;
	logic [AW-1:0] ord_waddr, ord_raddr, key_raddr;
	logic [AW-1:0] ord_wdata, ord_rdata;
	vkey_t         key_rdata;

	vdst_ram #(.WIDTH(AW), .DEPTH(TABLE_DEPTH)) u_ord (
		.clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
		.raddr(ord_raddr), .rdata(ord_rdata)
	);

	vdst_ram #(.WIDTH(KeyW), .DEPTH(TABLE_DEPTH)) u_key (
		.clk(clk), .we(key_we), .waddr(count_q[AW-1:0]), .wdata(key_q),
		.raddr(key_raddr), .rdata(key_rdata)
	);

	// shared compare: stored key vs search key, z then y then x
	logic st_gt, st_eq;
	assign st_eq = (key_rdata == key_q);
	assign st_gt = (key_rdata > key_q);

	logic [CW-1:0] mid_w;
	assign mid_w = lo_q + ((hi_q - lo_q) >> 1);

	assign key_raddr = ord_rdata;
	always_comb begin
		ord_raddr = mid_q;
		if (state_q == S_SHRD) begin
			ord_raddr = AW'(pos_q - CW'(1));
		end
	end

	assign ord_we    = (state_q == S_SHWR) || (state_q == S_DONE);
	assign ord_waddr = pos_q[AW-1:0];
	assign ord_wdata = (state_q == S_DONE) ? count_q[AW-1:0] : ord_rdata;
	assign key_we    = (state_q == S_DONE);

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			pos_q        <= '0;
			mid_q        <= '0;
			key_q        <= '0;
			vertex_index <= '0;
			is_new       <= 1'b0;
			table_full   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						key_q   <= {order_key(coord_z), order_key(coord_y), order_key(coord_x)};
						lo_q    <= '0;
						hi_q    <= restart ? '0 : count_q;
						if (restart) begin
							count_q <= '0;
						end
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid_w[AW-1:0];
						pos_q   <= mid_w;
						state_q <= S_RDORD;
					end else if (count_q == DepthC) begin
						vertex_index <= '0;
						is_new       <= 1'b0;
						table_full   <= 1'b1;
						state_q      <= S_OUT;
					end else begin
						pos_q   <= count_q;
						state_q <= (count_q == lo_q) ? S_DONE : S_SHRD;
					end
				end
				S_RDORD: state_q <= S_RDKEY;
				S_RDKEY: state_q <= S_CMP;
				S_CMP: begin
					if (st_eq) begin
						vertex_index <= 10'(ord_rdata);
						is_new       <= 1'b0;
						table_full   <= 1'b0;
						state_q      <= S_OUT;
					end else begin
						if (st_gt) begin
							lo_q <= pos_q + CW'(1);
						end else begin
							hi_q <= pos_q;
						end
						state_q <= S_PROBE;
					end
				end
				// move one sorted entry up per pass, from the top down to lo
				S_SHRD: state_q <= S_SHWR;
				S_SHWR: begin
					pos_q   <= pos_q - CW'(1);
					state_q <= (pos_q - CW'(1) == lo_q) ? S_DONE : S_SHRD;
				end
				S_DONE: begin
					vertex_index <= 10'(count_q);
					is_new       <= 1'b1;
					table_full   <= 1'b0;
					count_q      <= count_q + CW'(1);
					state_q      <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: verif/vertex_dedup_sorted_table_checker.sv
// ----------------------------------------------------------------------------
// vertex_dedup_sorted_table_checker
// watches both channels, predicts each lookup result and compares it
// ----------------------------------------------------------------------------
module vertex_dedup_sorted_table_checker #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  vdst_pkg::coord_t coord_x,
	input  vdst_pkg::coord_t coord_y,
	input  vdst_pkg::coord_t coord_z,
	input  logic             restart,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic [9:0]       vertex_index,
	input  logic             is_new,
	input  logic             table_full,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [9:0] index;
		logic       fresh;
		logic       full;
	} lookup_t;

	vdst_pkg::vkey_t weld_keys[TABLE_DEPTH];
	int unsigned     by_position[TABLE_DEPTH];
	int unsigned     weld_count;
	lookup_t         lookups_due[$];

	function automatic logic [31:0] sort_key(input logic [31:0] raw);
		logic [31:0] b;
		b = raw;
		if (b[30:0] == '0) b = '0;
		return b[31] ? ~b : {1'b1, b[30:0]};
	endfunction

	// search the sorted list, insert on a miss while the table has room
	function automatic lookup_t weld_vertex(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic rst);
		vdst_pkg::vkey_t k;
		int unsigned lo, hi, mid, si;
		lookup_t r;
		if (rst) weld_count = 0;
		k = {sort_key(z), sort_key(y), sort_key(x)};
		lo = 0;
		hi = weld_count;
		while (lo < hi) begin
			mid = lo + ((hi - lo) >> 1);
			si = by_position[mid];
			if (weld_keys[si] == k) begin
				r = '{index: si[9:0], fresh: 1'b0, full: 1'b0};
				return r;
			end
			if (weld_keys[si] > k) lo = mid + 1;
			else hi = mid;
		end
		if (weld_count >= TABLE_DEPTH) begin
			r = '{index: '0, fresh: 1'b0, full: 1'b1};
			return r;
		end
		weld_keys[weld_count] = k;
		for (int unsigned i = weld_count; i > lo; i--) by_position[i] = by_position[i-1];
		by_position[lo] = weld_count;
		r = '{index: weld_count[9:0], fresh: 1'b1, full: 1'b0};
		weld_count++;
		return r;
	endfunction

	initial begin
		fail_count = 0;
		pending = 0;
		weld_count = 0;
	end

	always @(posedge clk) begin
		lookup_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				lookups_due.push_back(weld_vertex(coord_x, coord_y, coord_z, restart));
			if (out_valid && !out_stall) begin
				if (lookups_due.size() == 0) begin
					$display("%0t: unexpected beat idx=%0d new=%b full=%b", $time,
						vertex_index, is_new, table_full);
					fail_count++;
				end else begin
					want = lookups_due.pop_front();
					if (want.index !== vertex_index || want.fresh !== is_new ||
							want.full !== table_full) begin
						$display("%0t: expected idx=%0d new=%b full=%b, got idx=%0d new=%b full=%b",
							$time, want.index, want.fresh, want.full, vertex_index, is_new,
							table_full);
						fail_count++;
					end
				end
			end
			pending = lookups_due.size();
		end
	end

endmodule

FILE: verif/vertex_dedup_sorted_table_top_tb.sv
// ----------------------------------------------------------------------------
// vertex_dedup_sorted_table_top_tb
// drives vertices with random gaps and stalls; checker predicts the indices
// ----------------------------------------------------------------------------
module vertex_dedup_sorted_table_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH = 1024;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	vdst_pkg::coord_t coord_x, coord_y, coord_z;
	logic             restart;
	logic             out_valid;
	logic             out_stall;
	logic [9:0]       vertex_index;
	logic             is_new;
	logic             table_full;
	int               fail_count;
	int               pending;

	logic [31:0] pool[$];

	vertex_dedup_sorted_table_top #(.TABLE_DEPTH(DEPTH)) DUT (.*);
	vertex_dedup_sorted_table_checker #(.TABLE_DEPTH(DEPTH)) u_checker (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#400ms;
		$display("FAILURE");
		$finish;
	end

	// receiver stalls for a random length before each beat, sometimes not at all
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!(out_valid && !out_stall)) @(posedge clk);
		end
	end

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'h0000_0000;
			2: return 32'h8000_0000;
			default: return pool[$urandom_range(0, pool.size() - 1)];
		endcase
	endfunction

	task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic rst, input bit gap);
		int n;
		n = gap ? $urandom_range(0, 9) : 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		coord_x  <= x;
		coord_y  <= y;
		coord_z  <= z;
		restart  <= rst;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		bit gap;
		in_valid = 1'b0;
		coord_x = '0;
		coord_y = '0;
		coord_z = '0;
		restart = 1'b0;
		arst_n = 1'b0;
		pool = '{32'h3F80_0000, 32'hBF80_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
			32'h7F80_0000, 32'hFF80_0000, 32'h0000_0001, 32'h8000_0001,
			32'h4000_0000, 32'hC040_0000, 32'h3F00_0000, 32'h0080_0000};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: signed zeros, extremes, repeats, restart
		send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
		send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0);
		send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
		send_vertex(32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF, 1'b0, 1'b0);
		send_vertex(32'hFF80_0000, 32'h7F80_0000, 32'hFF7F_FFFF, 1'b0, 1'b0);
		send_vertex(32'h0000_0001, 32'h8000_0001, 32'h0000_0000, 1'b0, 1'b0);
		send_vertex(32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000, 1'b0, 1'b1);
		send_vertex(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b0, 1'b1);
		send_vertex(32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF, 1'b0, 1'b1);
		send_vertex(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b1, 1'b1);
		send_vertex(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b0, 1'b1);
		send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1);
		drain();

		// fill the table, then send new vertices that miss while it is full
		send_vertex($urandom(), $urandom(), $urandom(), 1'b1, 1'b0);
		for (int i = 1; i < DEPTH; i++)
			send_vertex($urandom(), $urandom(), $urandom(), 1'b0, ($urandom_range(0, 7) == 0));
		send_vertex(32'h1234_5678, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1);
		send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1);
		drain();

		// random: small tables over a value pool so hits are common
		for (int i = 0; i < 900; i++) begin
			gap = (i % 200) >= 100;
			if ($urandom_range(0, 15) == 0) pool.push_back($urandom());
			send_vertex(pick_coord(), pick_coord(), pick_coord(),
				($urandom_range(0, 59) == 0), gap);
			if (i == 450) drain();
		end
		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
